// ===== src/parity_frame_receiver_macros.svh =====
// ----------------------------------------------------------------------------
// parity frame receiver assertion macros
// concurrent assertion shorthands for the receiver core
// ----------------------------------------------------------------------------
`ifndef PARITY_FRAME_RECEIVER_MACROS_SVH
`define PARITY_FRAME_RECEIVER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define PFR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pfr assertion failed");

// next-cycle implication, disabled while reset is asserted
`define PFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pfr assertion failed");

`endif

// ===== src/pfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfr_pkg
// types and constants shared by the parity frame receiver modules
// ----------------------------------------------------------------------------
package pfr_pkg;

    localparam int unsigned FRAME_BITS   = 16;
    localparam int unsigned DATA_BITS    = 12;
    localparam int unsigned TICK_W       = 16;
    localparam int unsigned BITS_LEFT_W  = 5;
    localparam int unsigned CFG_DATA_W   = 16;
    localparam int unsigned CFG_ADDR_W   = 1;
    localparam int unsigned IN_TDATA_W   = 8;
    localparam int unsigned OUT_TDATA_W  = 32;

    localparam logic [TICK_W-1:0]      BIT_TICKS_RESET = 16'd500;
    localparam logic [BITS_LEFT_W-1:0] BITS_PER_FRAME  = 5'd16;

    // configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_BIT_TICKS     = 1'b0,
        REG_LISTEN_ENABLE = 1'b1
    } t_reg_idx;

    // frame result codes
    typedef enum logic [1:0] {
        ST_INVALID  = 2'd0,
        ST_SAMPLE   = 2'd1,
        ST_MATCH    = 2'd2,
        ST_RELOADED = 2'd3
    } t_status;

    typedef struct packed {
        logic [TICK_W-1:0] bit_ticks;
        logic              listen_enable;
    } t_cfg;

    typedef struct packed {
        t_status              frame_status;
        logic [DATA_BITS-1:0] payload;
        logic [DATA_BITS-1:0] count_now;
    } t_result;

endpackage

// ===== src/pfr_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfr_core
// bit timing, shift register and frame check; one tick per advance
// ----------------------------------------------------------------------------
`include "parity_frame_receiver_macros.svh"

module pfr_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pfr_pkg::t_cfg   i_cfg,
    input  logic            i_advance,
    input  logic            i_level,
    output logic            o_result_valid,
    output pfr_pkg::t_result o_result
);
    import pfr_pkg::*;

    logic                   r_busy;
    logic [TICK_W-1:0]      r_tick_count;
    logic [BITS_LEFT_W-1:0] r_bits_left;
    logic [FRAME_BITS-1:0]  r_shift_word;
    logic [DATA_BITS-1:0]   r_rx_count;

    logic                   n_busy;
    logic [TICK_W-1:0]      n_tick_count;
    logic [BITS_LEFT_W-1:0] n_bits_left;
    logic [FRAME_BITS-1:0]  n_shift_word;
    logic [DATA_BITS-1:0]   n_rx_count;

    logic [TICK_W-1:0]      w_period;
    logic [TICK_W:0]        w_next_tick;
    logic                   w_sample;
    logic [BITS_LEFT_W-1:0] w_bits_dec;
    logic [FRAME_BITS-1:0]  w_word;
    logic [DATA_BITS-1:0]   w_data;
    logic                   w_frame_ok;
    logic                   w_start;

    // bit period, zero treated as one
    assign w_period    = (i_cfg.bit_ticks == '0) ? TICK_W'(1) : i_cfg.bit_ticks;
    assign w_next_tick = {1'b0, r_tick_count} + (TICK_W+1)'(1);
    assign w_sample    = r_busy && (w_next_tick >= {1'b0, w_period});
    assign w_bits_dec  = r_bits_left - BITS_LEFT_W'(1);
    assign w_word      = {r_shift_word[FRAME_BITS-2:0], i_level};
    assign w_data      = w_word[DATA_BITS+1:2];
    assign w_start     = !r_busy && i_cfg.listen_enable && i_level;

    // start bit, stop bit and even parity over the data
    assign w_frame_ok  = w_word[FRAME_BITS-1] && w_word[0] && (w_word[1] == ^w_data);

    // next state and result decode
    always_comb begin
        n_busy         = r_busy;
        n_tick_count   = r_tick_count;
        n_bits_left    = r_bits_left;
        n_shift_word   = r_shift_word;
        n_rx_count     = r_rx_count;
        o_result_valid = 1'b0;
        o_result.frame_status = ST_INVALID;
        o_result.payload      = w_data;
        o_result.count_now    = r_rx_count;
        if (i_advance) begin
            if (w_start) begin
                n_busy       = 1'b1;
                n_tick_count = '0;
                n_bits_left  = BITS_PER_FRAME;
                n_shift_word = '0;
            end else if (r_busy && !w_sample) begin
                n_tick_count = w_next_tick[TICK_W-1:0];
            end else if (w_sample) begin
                n_tick_count = '0;
                n_shift_word = w_word;
                n_bits_left  = w_bits_dec;
                if (w_bits_dec == '0) begin
                    n_busy         = 1'b0;
                    o_result_valid = 1'b1;
                    priority if (!w_frame_ok) begin
                        o_result.frame_status = ST_INVALID;
                    end else if (!w_word[FRAME_BITS-2]) begin
                        n_rx_count = r_rx_count + DATA_BITS'(1);
                        o_result.frame_status = ST_SAMPLE;
                    end else if (w_data == r_rx_count) begin
                        o_result.frame_status = ST_MATCH;
                    end else begin
                        n_rx_count = w_data;
                        o_result.frame_status = ST_RELOADED;
                    end
                    o_result.count_now = n_rx_count;
                end
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_tick_count <= '0;
            r_bits_left  <= '0;
            r_shift_word <= '0;
            r_rx_count   <= '0;
        end else begin
            r_busy       <= n_busy;
            r_tick_count <= n_tick_count;
            r_bits_left  <= n_bits_left;
            r_shift_word <= n_shift_word;
            r_rx_count   <= n_rx_count;
        end
    end

    // checks on the frame sequencing
    `PFR_ASSERT_SAME(a_result_needs_busy, i_clk, i_rst_n, o_result_valid, r_busy && i_advance)
    `PFR_ASSERT_NEXT(a_result_ends_frame, i_clk, i_rst_n, o_result_valid, !r_busy)
    `PFR_ASSERT_SAME(a_bits_left_range, i_clk, i_rst_n, r_busy,
        (r_bits_left != '0) && (r_bits_left <= BITS_PER_FRAME))
    `PFR_ASSERT_NEXT(a_start_loads_frame, i_clk, i_rst_n, i_advance && w_start,
        r_busy && (r_bits_left == BITS_PER_FRAME) && (r_tick_count == '0))

endmodule

// ===== src/parity_frame_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// parity_frame_receiver
// even-parity serial frame receiver driven by one line sample per tick
// ----------------------------------------------------------------------------
// usage:
//   slave stream: one transaction per tick, s_axis_tdata[0] is the sampled
//   line level. master stream: one transaction per completed 16-bit frame
//   carrying status, payload and the received sample count.
//   configuration: write bit_ticks (index 0) and listen_enable (index 1)
//   through i_cfg_we / i_cfg_addr / i_cfg_wdata while the receiver is idle.
// result path: a frame result reaches the master side through the input register
//   and then the result register, after the transaction carrying its sixteenth sample.
// throughput: one tick per cycle while the result register can take a frame; the
//   input register and the frame state update advance together, the result register
//   decouples the master side.
// reset: bit_ticks returns to 500, listening is off, the frame state and
//   the sample count clear, both streams come up empty.
// stall: while a result waits on the master side, the next tick is held in
//   the input register and s_axis_tready stays low until it drains.
// ----------------------------------------------------------------------------
module parity_frame_receiver (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [pfr_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [pfr_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    // tick stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [pfr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [0] line_level
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [pfr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata   // [1:0] frame_status,
                                                              // [13:2] payload,
                                                              // [25:14] count_now
);
    import pfr_pkg::*;

    t_cfg    r_cfg;
    logic    r_in_valid;
    logic    r_in_level;
    logic    r_out_valid;
    t_result r_out;

    logic    w_advance;
    logic    w_res_valid;
    t_result w_res;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bit_ticks     <= BIT_TICKS_RESET;
            r_cfg.listen_enable <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_addr))
                REG_BIT_TICKS:     r_cfg.bit_ticks     <= i_cfg_wdata;
                REG_LISTEN_ENABLE: r_cfg.listen_enable <= i_cfg_wdata[0];
                default:           r_cfg               <= r_cfg;
            endcase
        end
    end

    // the held tick moves on when the result register can take a frame
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_level <= s_axis_tdata[0];
        end
    end

    pfr_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_advance      (w_advance),
        .i_level        (r_in_level),
        .o_result_valid (w_res_valid),
        .o_result       (w_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - 2 - 2*DATA_BITS){1'b0}},
                            r_out.count_now, r_out.payload, r_out.frame_status};

endmodule

// ===== sim/pfr_frame_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfr_frame_checker
// watches the tick, result and configuration ports of the receiver, runs
// its own copy of the frame logic on every accepted tick and compares each
// result transaction against the oldest predicted frame
// ----------------------------------------------------------------------------
module pfr_frame_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port, observed
    input  logic                            i_cfg_we,
    input  logic [pfr_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [pfr_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    // tick stream, observed
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    input  logic [pfr_pkg::IN_TDATA_W-1:0]  i_s_tdata,   // [0] line_level
    // result stream, observed
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [pfr_pkg::OUT_TDATA_W-1:0] i_m_tdata,   // [1:0] frame_status,
                                                         // [13:2] payload,
                                                         // [25:14] count_now
    // status for the stimulus side
    output int                              o_fail_count,
    output int                              o_frames_waiting,
    output int                              o_frames_checked,
    output int                              o_invalid_frames,
    output logic [pfr_pkg::DATA_BITS-1:0]   o_rx_count
);
    import pfr_pkg::*;

    // configuration copy
    logic [TICK_W-1:0]      bit_ticks;
    logic                   listen;

    // frame state copy
    logic                   busy;
    logic [TICK_W-1:0]      tick_count;
    logic [BITS_LEFT_W-1:0] bits_left;
    logic [FRAME_BITS-1:0]  shift_word;
    logic [DATA_BITS-1:0]   rx_count;

    t_result                frames_due[$];
    t_result                seen_frame;
    t_result                due_frame;

    // one tick of the receiver: start detection, bit sampling, frame decode
    task automatic advance_receiver(input logic level);
        logic [TICK_W:0]      next_count;
        logic [TICK_W-1:0]    period;
        logic [DATA_BITS-1:0] data;
        t_result              frame;
        period = (bit_ticks == '0) ? TICK_W'(1) : bit_ticks;
        if (!busy) begin
            if (listen && level) begin
                busy       = 1'b1;
                tick_count = '0;
                bits_left  = BITS_PER_FRAME;
                shift_word = '0;
            end
        end else begin
            next_count = {1'b0, tick_count} + 1'b1;
            if (next_count < {1'b0, period}) begin
                tick_count = next_count[TICK_W-1:0];
            end else begin
                tick_count = '0;
                shift_word = {shift_word[FRAME_BITS-2:0], level};
                bits_left  = bits_left - 1'b1;
                if (bits_left == '0) begin
                    busy          = 1'b0;
                    data          = shift_word[DATA_BITS+1:2];
                    frame.payload = data;
                    // start high, stop high, even parity over the data field
                    if (!shift_word[FRAME_BITS-1] || !shift_word[0]
                            || shift_word[1] != ^data) begin
                        frame.frame_status = ST_INVALID;
                    end else if (!shift_word[FRAME_BITS-2]) begin
                        rx_count           = rx_count + 1'b1;
                        frame.frame_status = ST_SAMPLE;
                    end else if (data == rx_count) begin
                        frame.frame_status = ST_MATCH;
                    end else begin
                        rx_count           = data;
                        frame.frame_status = ST_RELOADED;
                    end
                    frame.count_now = rx_count;
                    frames_due.push_back(frame);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            bit_ticks        = BIT_TICKS_RESET;
            listen           = 1'b0;
            busy             = 1'b0;
            tick_count       = '0;
            bits_left        = '0;
            shift_word       = '0;
            rx_count         = '0;
            o_fail_count     = 0;
            o_frames_checked = 0;
            o_invalid_frames = 0;
            frames_due.delete();
        end else begin
            // result transaction against the oldest predicted frame
            if (i_m_tvalid && i_m_tready) begin
                seen_frame.frame_status = t_status'(i_m_tdata[1:0]);
                seen_frame.payload      = i_m_tdata[DATA_BITS+1:2];
                seen_frame.count_now    = i_m_tdata[2*DATA_BITS+1:DATA_BITS+2];
                if (frames_due.size() == 0) begin
                    $display("%0t ns: result %08h arrived with no frame expected",
                             $time, i_m_tdata);
                    o_fail_count++;
                end else begin
                    due_frame = frames_due.pop_front();
                    o_frames_checked++;
                    if (due_frame.frame_status == ST_INVALID)
                        o_invalid_frames++;
                    if (seen_frame.frame_status !== due_frame.frame_status
                            || seen_frame.payload !== due_frame.payload
                            || seen_frame.count_now !== due_frame.count_now
                            || i_m_tdata[OUT_TDATA_W-1:2*DATA_BITS+2] !== '0) begin
                        $display({"%0t ns: result mismatch, expected status %0d payload %03h ",
                                  "count %03h, got status %0d payload %03h count %03h pad %02h"},
                                 $time, due_frame.frame_status, due_frame.payload,
                                 due_frame.count_now, seen_frame.frame_status,
                                 seen_frame.payload, seen_frame.count_now,
                                 i_m_tdata[OUT_TDATA_W-1:2*DATA_BITS+2]);
                        o_fail_count++;
                    end
                end
            end
            // tick transaction
            if (i_s_tvalid && i_s_tready)
                advance_receiver(i_s_tdata[0]);
            // register writes
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_BIT_TICKS:     bit_ticks = i_cfg_wdata[TICK_W-1:0];
                    REG_LISTEN_ENABLE: listen    = i_cfg_wdata[0];
                    default: ;
                endcase
            end
        end
        o_frames_waiting = frames_due.size();
        o_rx_count       = rx_count;
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives line ticks and register writes into the parity frame receiver:
// directed frames for the boundary cases, then random phases of frames,
// noise and corrupted words under random stalls on both streams
// ----------------------------------------------------------------------------
module testbench;
    import pfr_pkg::*;

    localparam int IDLE_LIMIT  = 2000;
    localparam int TOTAL_TICKS = 1850;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_COUNT  = 1'b1;

    localparam int START_POS  = 15;
    localparam int PARITY_POS = 1;
    localparam int STOP_POS   = 0;

    typedef enum int {
        FLAW_NONE,
        FLAW_START,
        FLAW_STOP,
        FLAW_PARITY
    } t_flaw;

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata   = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // [0] line_level
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;         // [1:0] frame_status, [13:2] payload,
                                                  // [25:14] count_now

    int                     fail_count;
    int                     frames_waiting;
    int                     frames_checked;
    int                     invalid_frames;
    logic [DATA_BITS-1:0]   model_count;

    bit                     burst_mode = 1'b0;
    int                     ticks_sent = 0;

    parity_frame_receiver u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    pfr_frame_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_s_tvalid       (s_axis_tvalid),
        .i_s_tready       (s_axis_tready),
        .i_s_tdata        (s_axis_tdata),
        .i_m_tvalid       (m_axis_tvalid),
        .i_m_tready       (m_axis_tready),
        .i_m_tdata        (m_axis_tdata),
        .o_fail_count     (fail_count),
        .o_frames_waiting (frames_waiting),
        .o_frames_checked (frames_checked),
        .o_invalid_frames (invalid_frames),
        .o_rx_count       (model_count)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // frame word: start, mode, data, even parity, stop, with an optional flaw
    function automatic logic [FRAME_BITS-1:0] make_word(input logic mode,
                                                        input logic [DATA_BITS-1:0] data,
                                                        input t_flaw flaw);
        logic [FRAME_BITS-1:0] word;
        word = {1'b1, mode, data, ^data, 1'b1};
        case (flaw)
            FLAW_START:  word[START_POS]  = 1'b0;
            FLAW_STOP:   word[STOP_POS]   = 1'b0;
            FLAW_PARITY: word[PARITY_POS] = ~word[PARITY_POS];
            default: ;
        endcase
        return word;
    endfunction

    // one tick transaction, entered and left at a falling edge
    task automatic send_tick(input logic level);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W-1){1'b0}}, level};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        ticks_sent++;
        @(negedge i_clk);
    endtask

    // bits hi..lo of a word, each over a bit period (random filler ticks with jitter), last tick sampled
    task automatic send_bits(input logic [FRAME_BITS-1:0] word, input int hi, input int lo,
                             input int period, input bit jitter);
        for (int b = hi; b >= lo; b--) begin
            repeat (period - 1) begin
                if (jitter)
                    send_tick(1'($urandom_range(0, 1)));
                else
                    send_tick(word[b]);
            end
            send_tick(word[b]);
        end
    endtask

    task automatic send_frame(input logic [FRAME_BITS-1:0] word, input int period,
                              input bit jitter);
        send_tick(1'b1);
        send_bits(word, FRAME_BITS - 1, 0, period, jitter);
    endtask

    // park the tick stream until no frame is outstanding and the pipe is empty
    task automatic settle_receiver();
        s_axis_tvalid <= 1'b0;
        while (frames_waiting != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] value);
        settle_receiver();
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // result side ready pattern
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                hold--;
            end else if (burst_mode || $urandom_range(0, 9) < 7) begin
                m_axis_tready <= 1'b1;
                hold = $urandom_range(0, 7);
            end else begin
                m_axis_tready <= 1'b0;
                hold = pick_gap();
            end
        end
    end

    // watchdog on cycles without any transaction
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog expired at %0t ns with %0d frames outstanding",
                 $time, frames_waiting);
        $display("status: fail");
        $finish;
    end

    // stimulus
    initial begin
        logic [FRAME_BITS-1:0] word;
        logic [CFG_DATA_W-1:0] period_setting;
        logic [DATA_BITS-1:0]  data;
        logic                  mode;
        t_flaw                 flaw;
        int                    period;
        int                    tick_goal;
        int                    phase_frames;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset defaults: listening off, high ticks ignored
        repeat (6) send_tick(1'b1);
        write_reg(REG_BIT_TICKS, 16'd1);
        write_reg(REG_LISTEN_ENABLE, 16'd1);

        // directed frames, back to back, no stalls
        burst_mode = 1'b1;
        send_frame(make_word(MODE_SAMPLE, 12'h000, FLAW_NONE), 1, 1'b0);
        send_frame(make_word(MODE_SAMPLE, 12'hFFF, FLAW_NONE), 1, 1'b0);
        send_frame(make_word(MODE_COUNT, model_count, FLAW_NONE), 1, 1'b0);
        send_frame(make_word(MODE_COUNT, 12'hFFF, FLAW_NONE), 1, 1'b0);
        // count wraps from 4095 to 0
        send_frame(make_word(MODE_SAMPLE, 12'hA5A, FLAW_NONE), 1, 1'b0);
        send_frame(make_word(MODE_COUNT, 12'h000, FLAW_NONE), 1, 1'b0);
        send_frame(make_word(MODE_SAMPLE, 12'h800, FLAW_START), 1, 1'b0);
        send_frame(make_word(MODE_COUNT, 12'h001, FLAW_STOP), 1, 1'b0);
        send_frame(make_word(MODE_SAMPLE, 12'h5A5, FLAW_PARITY), 1, 1'b0);
        send_frame(make_word(MODE_COUNT, 12'h7FF, FLAW_PARITY), 1, 1'b0);
        send_frame(make_word(MODE_COUNT, 12'h800, FLAW_NONE), 1, 1'b0);
        burst_mode = 1'b0;

        // zero bit period acts as one
        write_reg(REG_BIT_TICKS, 16'd0);
        send_frame(make_word(MODE_SAMPLE, 12'h3C3, FLAW_NONE), 1, 1'b0);
        send_frame(make_word(MODE_COUNT, model_count, FLAW_NONE), 1, 1'b0);

        // period shortened at a bit boundary, noisy filler ticks
        write_reg(REG_BIT_TICKS, 16'd3);
        word = make_word(MODE_SAMPLE, 12'h9E1, FLAW_NONE);
        send_tick(1'b1);
        send_bits(word, FRAME_BITS - 1, 9, 3, 1'b1);
        write_reg(REG_BIT_TICKS, 16'd2);
        send_bits(word, 8, 0, 2, 1'b1);

        // largest period, cut down in the middle of the start bit
        write_reg(REG_BIT_TICKS, 16'hFFFF);
        word = make_word(MODE_COUNT, 12'h123, FLAW_NONE);
        send_tick(1'b1);
        repeat (300) send_tick(1'b1);
        write_reg(REG_BIT_TICKS, 16'd1);
        send_bits(word, FRAME_BITS - 1, 0, 1, 1'b0);

        // listening switched off mid-frame: the frame still completes
        word = make_word(MODE_SAMPLE, 12'h0F0, FLAW_NONE);
        send_tick(1'b1);
        send_bits(word, FRAME_BITS - 1, 8, 1, 1'b0);
        write_reg(REG_LISTEN_ENABLE, 16'd0);
        send_bits(word, 7, 0, 1, 1'b0);
        repeat (8) send_tick(1'b1);
        write_reg(REG_LISTEN_ENABLE, 16'd1);

        // random phases, one bit period each, until the tick budget is spent
        tick_goal = TOTAL_TICKS;
        while (ticks_sent < tick_goal) begin
            case ($urandom_range(0, 7))
                0:       period_setting = 16'd0;
                1, 2:    period_setting = 16'd1;
                3, 4:    period_setting = 16'd2;
                5:       period_setting = 16'd3;
                6:       period_setting = 16'd5;
                default: period_setting = CFG_DATA_W'($urandom_range(6, 9));
            endcase
            period = (period_setting == '0) ? 1 : int'(period_setting);
            write_reg(REG_BIT_TICKS, period_setting);
            burst_mode   = ($urandom_range(0, 3) == 0);
            phase_frames = $urandom_range(4, 10);
            for (int f = 0; f < phase_frames && ticks_sent < tick_goal; f++) begin
                if ($urandom_range(0, 99) < 10) begin
                    // line noise, then a quiet stretch long enough to end any frame
                    repeat ($urandom_range(4, 24)) send_tick(1'($urandom_range(0, 1)));
                    repeat (16 * period + 2) send_tick(1'b0);
                end else begin
                    mode = 1'($urandom_range(0, 1));
                    if (mode == MODE_COUNT && $urandom_range(0, 1) == 1)
                        data = model_count;
                    else
                        data = DATA_BITS'($urandom_range(0, 4095));
                    flaw = ($urandom_range(0, 99) < 85) ? FLAW_NONE
                                                        : t_flaw'($urandom_range(1, 3));
                    send_frame(make_word(mode, data, flaw), period,
                               $urandom_range(0, 2) == 0);
                    repeat ($urandom_range(0, 3)) send_tick(1'b0);
                end
            end
        end

        settle_receiver();
        repeat (10) @(negedge i_clk);

        $display("covered %0d line ticks and %0d checked frames, %0d of them invalid",
                 ticks_sent, frames_checked, invalid_frames);
        $display("bit periods from 0 to 65535, mid-frame period and listen changes, count wrap");
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
